@@ design/fts_pkg.sv @@
// ----------------------------------------------------------------------------
// fts_pkg - shared constants for the trapezoid weighted select block
// Widths of the breakpoint table, weights and running sums.
// ----------------------------------------------------------------------------
package fts_pkg;
    localparam int MAX_MEMBERS = 16;
    localparam int CORNERS     = 4;
    localparam int VALUE_BITS  = 16;
    localparam int MEM_W       = $clog2(MAX_MEMBERS);
    localparam int ADDR_W      = MEM_W + 2;
    localparam int W_BITS      = 16;
    localparam int TOT_W       = W_BITS + MEM_W;
    localparam int RND_W       = 14;
    localparam int PROD_W      = TOT_W + RND_W;
    localparam int CNT_W       = 5;
    localparam logic [W_BITS-1:0] W_ONE = '1;
endpackage

@@ design/fts_div.sv @@
// ----------------------------------------------------------------------------
// fts_div - serial ramp divider
// Computes floor(num * 2^16 / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fts_div import fts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W_BITS-1:0] i_num,
    input  logic [W_BITS-1:0] i_den,
    output logic              o_done,
    output logic [W_BITS-1:0] o_quot
);
    logic [W_BITS-1:0] r_rem, r_den, r_q;
    logic [4:0]        r_n;
    logic              r_done;
    logic [W_BITS:0]   w_t;
    logic              w_ge;

    assign w_t  = {r_rem, 1'b0};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_n <= 5'(W_BITS);
            end else if (r_n != '0) begin
                r_n <= r_n - 5'd1;
                if (r_n == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_n != '0) begin
            // shift in one quotient bit, subtract when it fits
            r_rem <= w_ge ? W_BITS'(w_t - {1'b0, r_den}) : w_t[W_BITS-1:0];
            r_q   <= {r_q[W_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ design/fuzzy_trapezoid_weighted_select.sv @@
// ----------------------------------------------------------------------------
// fuzzy_trapezoid_weighted_select - trapezoid membership and roulette pick
// Loads breakpoints into a table; an evaluate transaction weighs every
// active member and picks one by cumulative weight against a random number.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall. A transaction with i_action low writes one
// breakpoint (member, corner, value) and produces no result. A transaction
// with i_action high evaluates i_value and i_random.
// Output channel: o_valid / i_stall, one transaction (o_selected, o_none) per
// evaluate, held in an output register while the receiver stalls.
// Per member the sequencer reads four breakpoints through the single table
// read port, compares them and, on a ramp, runs the shared serial divider.
// The selection pass then walks the stored weights, one member a cycle.
// o_stall stays high for the whole evaluate.
// A finished result waits in its own state until the output register frees.
// member_count, written through i_cfg_we / i_cfg_data, must be written only
// while idle; the block does not enforce it. Reset (i_rst_n low, synchronous)
// returns to idle, empties the output and clears member_count; the breakpoint table is not cleared.
// ----------------------------------------------------------------------------
module fuzzy_trapezoid_weighted_select import fts_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CNT_W-1:0]             i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [3:0]                   i_member,
    input  logic [1:0]                   i_corner,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [RND_W-1:0]             i_random,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [3:0]                   o_selected,
    output logic                         o_none
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WEIGH = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SEL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [CNT_W-1:0] r_cfg, r_cnt, r_i;
    logic [2:0] r_k;
    logic signed [VALUE_BITS-1:0] r_x;
    logic [RND_W-1:0] r_rnd;
    logic signed [VALUE_BITS-1:0] r_bp [CORNERS];
    logic [W_BITS-1:0] r_w [MAX_MEMBERS];
    logic [TOT_W-1:0] r_tot, r_cum;
    logic [PROD_W-1:0] r_prod;
    logic r_res_none;
    logic [3:0] r_res_sel;
    logic r_ov, r_onone;
    logic [3:0] r_osel;

    // breakpoint table
    logic [VALUE_BITS-1:0] r_mem [MAX_MEMBERS*CORNERS];
    logic [VALUE_BITS-1:0] r_rdata;
    logic [ADDR_W-1:0]     w_raddr;
    logic                  w_acc;

    assign w_acc   = i_valid && !o_stall;
    assign w_raddr = {r_i[MEM_W-1:0], r_k[1:0]};

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_action) begin
            r_mem[{i_member[MEM_W-1:0], i_corner}] <= i_value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // weigh one member from its captured corners
    logic w_ramp, w_top;
    logic [W_BITS-1:0] w_num, w_den;
    always_comb begin
        w_ramp = 1'b0;
        w_top  = 1'b0;
        w_num  = W_BITS'(r_x - r_bp[0]);
        w_den  = W_BITS'(r_bp[1] - r_bp[0]);
        if (r_x > r_bp[0]) begin
            if (r_x < r_bp[1]) begin
                w_ramp = 1'b1;
            end else if (r_x <= r_bp[2]) begin
                w_top = 1'b1;
            end else if (r_x < r_bp[3]) begin
                w_ramp = 1'b1;
                w_num  = W_BITS'(r_bp[3] - r_x);
                w_den  = W_BITS'(r_bp[3] - r_bp[2]);
            end
        end
    end

    logic w_div_start, w_div_done;
    logic [W_BITS-1:0] w_quot;
    assign w_div_start = (r_state == S_WEIGH) && w_ramp;

    fts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // weight to store this cycle, if any
    logic              w_wr;
    logic [W_BITS-1:0] w_wv;
    always_comb begin
        w_wr = 1'b0;
        w_wv = '0;
        if (r_state == S_WEIGH && !w_ramp) begin
            w_wr = 1'b1;
            w_wv = w_top ? W_ONE : '0;
        end else if (r_state == S_DIV && w_div_done) begin
            w_wr = 1'b1;
            w_wv = w_quot;
        end
    end

    logic [TOT_W-1:0] w_tot_n, w_cum_n;
    logic             w_last, w_hit;
    assign w_tot_n = r_tot + TOT_W'(w_wv);
    assign w_cum_n = r_cum + TOT_W'(r_w[r_i[MEM_W-1:0]]);
    assign w_last  = (r_i + CNT_W'(1)) == r_cnt;
    assign w_hit   = r_prod <= {w_cum_n, {RND_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_w[r_i[MEM_W-1:0]] <= w_wv;
        end
        if (r_state == S_READ && r_k != 3'd0) begin
            r_bp[r_k[1:0] - 2'd1] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= '0;
            r_ov    <= 1'b0;
            r_i     <= '0;
            r_k     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            // drop the output once the receiver takes it, unless refilled below
            if (r_ov && !i_stall && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_action) begin
                        r_x   <= i_value;
                        r_rnd <= i_random;
                        r_cnt <= (r_cfg > CNT_W'(MAX_MEMBERS)) ? CNT_W'(MAX_MEMBERS) : r_cfg;
                        r_i   <= '0;
                        r_k   <= '0;
                        r_tot <= '0;
                        r_res_none <= 1'b1;
                        r_res_sel  <= '0;
                        r_state <= (r_cfg == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ: begin
                    // address corner k, capture corner k-1
                    if (r_k == 3'd4) begin
                        r_state <= S_WEIGH;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_WEIGH, S_DIV: begin
                    if (r_state == S_WEIGH && w_ramp) begin
                        r_state <= S_DIV;
                    end else if (w_wr) begin
                        r_tot <= w_tot_n;
                        r_k   <= '0;
                        if (w_last) begin
                            r_i     <= '0;
                            r_cum   <= '0;
                            r_prod  <= PROD_W'(r_rnd) * PROD_W'(w_tot_n);
                            r_state <= (w_tot_n == '0) ? S_OUT : S_SEL;
                        end else begin
                            r_i     <= r_i + CNT_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_SEL: begin
                    r_cum <= w_cum_n;
                    if (w_hit) begin
                        r_res_none <= 1'b0;
                        r_res_sel  <= r_i[3:0];
                        r_state    <= S_OUT;
                    end else if (w_last) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                S_OUT: begin
                    // hold the result until the output register is free
                    if (!r_ov || !i_stall) begin
                        r_ov    <= 1'b1;
                        r_osel  <= r_res_sel;
                        r_onone <= r_res_none;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_ov;
    assign o_selected = r_osel;
    assign o_none     = r_onone;

    a_div_only_weigh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL || r_state == S_DIV) |-> r_i < r_cnt)
        else $error("member index beyond count");
    a_none_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_onone) |-> r_osel == '0)
        else $error("selected set with none");
endmodule

@@ verif/fuzzy_trapezoid_weighted_select_test.sv @@
// ----------------------------------------------------------------------------
// fuzzy_trapezoid_weighted_select_test - self-checking bench for the block
// Fills the breakpoint table with trapezoids, then sends directed and random
// evaluate transactions under several member counts. A scoreboard predicts
// each pick and compares it with the result channel.
// ----------------------------------------------------------------------------
module fuzzy_trapezoid_weighted_select_test;
    import fts_pkg::*;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;
    localparam int   DRAIN_CYCLES = 40;

    // Scoreboard: own copy of the table and the member count, and the
    // queue of picks still owed by the block.
    class pick_scoreboard;
        logic signed [VALUE_BITS-1:0] corner_tab [MAX_MEMBERS*CORNERS];
        logic [CNT_W-1:0] active_count;
        logic [3:0]       owed_sel [$];
        logic             owed_none [$];
        int mismatches;
        int checked;
        int evals;
        int none_seen;

        function new();
            active_count = '0;
            mismatches = 0;
            checked = 0;
            evals = 0;
            none_seen = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] n);
            active_count = n;
        endfunction

        function longint member_weight(int m, longint x);
            longint a, b, c, d;
            a = corner_tab[m*CORNERS+0];
            b = corner_tab[m*CORNERS+1];
            c = corner_tab[m*CORNERS+2];
            d = corner_tab[m*CORNERS+3];
            if (!(x > a)) return 0;
            if (x < b) return ((x - a) << 16) / (b - a);
            if (x <= c) return longint'(W_ONE);
            if (x < d) return ((d - x) << 16) / (d - c);
            return 0;
        endfunction

        // Note an accepted input transaction; an evaluate owes one pick.
        function void note_input(logic act, logic [3:0] mem, logic [1:0] cor,
                                 logic signed [VALUE_BITS-1:0] val,
                                 logic [RND_W-1:0] rnd);
            int n;
            longint w [MAX_MEMBERS];
            longint total, run;
            logic [3:0] sel;
            logic nf;
            if (act == ACT_LOAD) begin
                corner_tab[mem*CORNERS+cor] = val;
                return;
            end
            n = (active_count > MAX_MEMBERS) ? MAX_MEMBERS : active_count;
            total = 0;
            for (int i = 0; i < n; i++) begin
                w[i] = member_weight(i, longint'(val));
                total += w[i];
            end
            sel = '0;
            nf = 1'b1;
            if (total != 0) begin
                run = 0;
                for (int i = 0; i < n; i++) begin
                    run += w[i];
                    if (nf && longint'(rnd) * total <= 16384 * run) begin
                        sel = i[3:0];
                        nf = 1'b0;
                    end
                end
            end
            owed_sel.push_back(sel);
            owed_none.push_back(nf);
            evals++;
        endfunction

        function void check_result(logic [3:0] sel, logic nf);
            logic [3:0] e_sel;
            logic e_none;
            checked++;
            if (owed_sel.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: selected=%0d none=%0d", sel, nf);
                return;
            end
            e_sel = owed_sel.pop_front();
            e_none = owed_none.pop_front();
            if (e_none) none_seen++;
            if (sel !== e_sel || nf !== e_none) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: selected exp %0d got %0d, none exp %0d got %0d",
                             e_sel, sel, e_none, nf);
            end
        endfunction

        function int pending();
            return owed_sel.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CNT_W-1:0]             i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_action;
    logic [3:0]                   i_member;
    logic [1:0]                   i_corner;
    logic signed [VALUE_BITS-1:0] i_value;
    logic [RND_W-1:0]             i_random;
    logic                         o_valid;
    logic                         i_stall;
    logic [3:0]                   o_selected;
    logic                         o_none;

    pick_scoreboard sb;
    bit quiet;      // stretches with no idling on either side
    int phases;

    fuzzy_trapezoid_weighted_select uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_member   (i_member),
        .i_corner   (i_corner),
        .i_value    (i_value),
        .i_random   (i_random),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_selected (o_selected),
        .o_none     (o_none)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #60_000_000;
        $display("timeout: %0d picks still owed", sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // Check every result transaction on the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_selected, o_none);
    end

    // Receiver: hold stall for a random count before each result.
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            k = quiet ? 0 : $urandom_range(0, 9);
            if (k > 0) begin
                i_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Send one transaction after a random gap; return on the accepting edge.
    task automatic send(logic act, logic [3:0] mem, logic [1:0] cor,
                        logic signed [VALUE_BITS-1:0] val, logic [RND_W-1:0] rnd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action <= act;
        i_member <= mem;
        i_corner <= cor;
        i_value  <= val;
        i_random <= rnd;
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(act, mem, cor, val, rnd);
    endtask

    // Hold off until every pick has arrived, let loads settle, then write
    // the member count while the block is idle.
    task automatic drain_and_set(logic [CNT_W-1:0] n);
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_count(n);
        phases++;
    endtask

    // Load a well-formed trapezoid a <= b <= c <= d around a centre.
    task automatic load_trapezoid(int m, int centre);
        int v [4];
        int top, rise, fall;
        top  = $urandom_range(0, 800);
        rise = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1500);
        fall = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1500);
        v[1] = centre - top;
        v[2] = centre + top;
        v[0] = v[1] - rise;
        v[3] = v[2] + fall;
        for (int c = 0; c < CORNERS; c++) begin
            if (v[c] < -32768) v[c] = -32768;
            if (v[c] > 32767) v[c] = 32767;
            send(ACT_LOAD, m[3:0], c[1:0], v[c][15:0], RND_W'($urandom));
        end
    endtask

    function automatic int member_centre(int m);
        return -28000 + m * 3700 + $urandom_range(0, 1000);
    endfunction

    // Evaluate input near a breakpoint of a member, or anywhere.
    function automatic logic signed [VALUE_BITS-1:0] pick_x(int n);
        int x, m;
        if (n == 0 || $urandom_range(0, 9) < 3) return VALUE_BITS'($urandom);
        m = $urandom_range(0, n - 1);
        x = int'(sb.corner_tab[m*CORNERS + $urandom_range(0, 3)])
            + $urandom_range(0, 1200) - 600;
        if (x < -32768) x = -32768;
        if (x > 32767) x = 32767;
        return x[15:0];
    endfunction

    initial begin
        int n, mem, r;
        sb = new();
        phases = 0;
        quiet = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_action   = ACT_LOAD;
        i_member   = '0;
        i_corner   = '0;
        i_value    = '0;
        i_random   = '0;
        i_stall    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole table before any evaluate reads it.
        for (int m = 0; m < MAX_MEMBERS - 1; m++)
            load_trapezoid(m, member_centre(m));
        // Last member spans the full range to its feet.
        send(ACT_LOAD, 4'd15, 2'd0, 16'sh8000, '0);
        send(ACT_LOAD, 4'd15, 2'd1, -16'sd100, '0);
        send(ACT_LOAD, 4'd15, 2'd2, 16'sd100, '0);
        send(ACT_LOAD, 4'd15, 2'd3, 16'sh7fff, '0);

        // Directed: no active members, then full count at the extremes.
        drain_and_set(5'd0);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd0, 14'd0);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sh7fff, 14'h3fff);
        drain_and_set(5'd16);
        send(ACT_EVAL, 4'hf, 2'd3, 16'sh8000, 14'd0);
        send(ACT_EVAL, 4'hf, 2'd3, 16'sh7fff, 14'h3fff);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd0, 14'h3fff);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd0, 14'd0);
        // Zero random where member 0 has no weight but member 1 has.
        send(ACT_EVAL, 4'd0, 2'd0, sb.corner_tab[1*CORNERS+1], 14'd0);
        // Exactly on each corner of member 3.
        for (int c = 0; c < CORNERS; c++)
            send(ACT_EVAL, 4'd0, 2'd0, sb.corner_tab[3*CORNERS+c], RND_W'($urandom));
        // Count above the table size clamps to the full table.
        drain_and_set(5'd31);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd0, 14'h2000);
        send(ACT_EVAL, 4'd0, 2'd0, sb.corner_tab[7*CORNERS+1], 14'h3fff);
        // Unordered breakpoints on member 1: corners in descending order.
        drain_and_set(5'd2);
        send(ACT_LOAD, 4'd1, 2'd0, 16'sd500, '0);
        send(ACT_LOAD, 4'd1, 2'd1, 16'sd200, '0);
        send(ACT_LOAD, 4'd1, 2'd2, 16'sd100, '0);
        send(ACT_LOAD, 4'd1, 2'd3, -16'sd300, '0);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd300, 14'h1000);
        send(ACT_EVAL, 4'd0, 2'd0, 16'sd150, 14'h3fff);
        drain_and_set(5'd1);
        send(ACT_EVAL, 4'd0, 2'd0, sb.corner_tab[1], 14'h3fff);

        // Random phases, each under its own member count.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: n = 16;
                1: n = 0;
                2: n = 31;
                3: n = 1;
                default: n = $urandom_range(0, 31);
            endcase
            drain_and_set(n[CNT_W-1:0]);
            quiet = (p % 3 == 2);
            if (n > MAX_MEMBERS) n = MAX_MEMBERS;
            for (int i = 0; i < 55; i++) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    mem = $urandom_range(0, MAX_MEMBERS - 1);
                    load_trapezoid(mem, member_centre(mem));
                end else if (r < 13) begin
                    // Noise: any value into any corner.
                    send(ACT_LOAD, 4'($urandom), 2'($urandom), VALUE_BITS'($urandom),
                         RND_W'($urandom));
                end else begin
                    send(ACT_EVAL, 4'($urandom), 2'($urandom), pick_x(n),
                         RND_W'($urandom));
                end
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d evaluates (%0d with no pick) over %0d member-count settings",
                 sb.evals, sb.none_seen, phases);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
